>>> rtl/mgtms_pkg.sv
// Shared types and constants for the motion gated temporal minimum select block.
// Used by every module under rtl/; depends on nothing else.
package mgtms_pkg;

   // Default run length limit; frame index saturates at MaxFramesDefault - 1
   localparam int unsigned MaxFramesDefault = 16;

   // Still threshold after reset: 0.01 in Q16.16 (0.1 pixel, squared)
   localparam logic [31:0] ThresholdReset = 32'd655;

   // Width of the chosen_frame result field
   localparam int unsigned IndexW = 4;

   // Gray conversion: (1868*B + 9617*G + 4899*R + 8192) >> 14
   localparam int unsigned GraySumW = 22;
   localparam logic [GraySumW-1:0] CoefBlue  = 22'd1868;
   localparam logic [GraySumW-1:0] CoefGreen = 22'd9617;
   localparam logic [GraySumW-1:0] CoefRed   = 22'd4899;
   localparam logic [GraySumW-1:0] GrayRound = 22'd8192;

   // One pixel color
   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } colour_type;

   // Word handed from the prep stage to the select stage
   typedef struct packed {
      logic       last;
      logic [7:0] gray;
      logic [30:0] sq_x;
      logic [30:0] sq_y;
      colour_type colour;
   } s1_word_type;

endpackage

>>> rtl/mgtms_prep.sv
// Input register and first pipeline stage: flow squares and gray value.
// Depends on mgtms_pkg.
module mgtms_prep (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     adv,
   input  logic                     req_valid,
   input  logic [7:0]               req_blue,
   input  logic [7:0]               req_green,
   input  logic [7:0]               req_red,
   input  logic signed [15:0]       req_flow_x,
   input  logic signed [15:0]       req_flow_y,
   input  logic                     req_last_frame,
   output logic                     s1_vld,
   output mgtms_pkg::s1_word_type   s1_word
);

   logic                      in_vld_ff;
   mgtms_pkg::colour_type     in_colour_ff;
   logic signed [15:0]        in_fx_ff;
   logic signed [15:0]        in_fy_ff;
   logic                      in_last_ff;

   logic signed [31:0]        prod_x;
   logic signed [31:0]        prod_y;
   logic [mgtms_pkg::GraySumW-1:0] gray_sum;
   mgtms_pkg::s1_word_type    s1_in;

   logic                      s1_vld_ff;
   mgtms_pkg::s1_word_type    s1_word_ff;

   // Input register valid
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (adv) begin
         in_vld_ff <= req_valid;
      end
   end

   // Input register payload, loaded on each accepted word
   always_ff @(posedge clock) begin
      if (adv && req_valid) begin
         in_colour_ff.blue  <= req_blue;
         in_colour_ff.green <= req_green;
         in_colour_ff.red   <= req_red;
         in_fx_ff           <= req_flow_x;
         in_fy_ff           <= req_flow_y;
         in_last_ff         <= req_last_frame;
      end
   end

   // Squared flow components and gray conversion
   always_comb begin
      prod_x   = in_fx_ff * in_fx_ff;
      prod_y   = in_fy_ff * in_fy_ff;
      gray_sum = mgtms_pkg::GraySumW'(in_colour_ff.blue)  * mgtms_pkg::CoefBlue
               + mgtms_pkg::GraySumW'(in_colour_ff.green) * mgtms_pkg::CoefGreen
               + mgtms_pkg::GraySumW'(in_colour_ff.red)   * mgtms_pkg::CoefRed
               + mgtms_pkg::GrayRound;
      s1_in.last   = in_last_ff;
      s1_in.gray   = gray_sum[21:14];
      // squares are never negative and stay below 2^31
      s1_in.sq_x   = prod_x[30:0];
      s1_in.sq_y   = prod_y[30:0];
      s1_in.colour = in_colour_ff;
   end

   // Stage 1 register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (adv) begin
         s1_vld_ff <= in_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && in_vld_ff) begin
         s1_word_ff <= s1_in;
      end
   end

   assign s1_vld  = s1_vld_ff;
   assign s1_word = s1_word_ff;

endmodule

>>> rtl/mgtms_select.sv
// Second stage: still test, running minimum, frame selection and result register.
// Depends on mgtms_pkg.
module mgtms_select #(
   parameter int unsigned MAX_FRAMES = mgtms_pkg::MaxFramesDefault
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     adv,
   input  logic                     s1_vld,
   input  mgtms_pkg::s1_word_type   s1_word,
   input  logic [31:0]              threshold,
   output logic                     rsp_valid,
   output logic [7:0]               rsp_out_blue,
   output logic [7:0]               rsp_out_green,
   output logic [7:0]               rsp_out_red,
   output logic [mgtms_pkg::IndexW-1:0] rsp_chosen_frame
);

   localparam int unsigned CntW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
   localparam logic [CntW-1:0] CntLast = CntW'(MAX_FRAMES - 1);

   logic [CntW-1:0]           cnt_ff,     cnt_in;
   logic [7:0]                min_ff,     min_in;
   logic [CntW-1:0]           sel_idx_ff, sel_idx_in;
   mgtms_pkg::colour_type     ref_col_ff, ref_col_in;
   mgtms_pkg::colour_type     sel_col_ff, sel_col_in;

   logic                      rsp_valid_ff;
   mgtms_pkg::colour_type     out_col_ff;
   logic [CntW-1:0]           out_idx_ff;
   logic [CntW+mgtms_pkg::IndexW-1:0] idx_ext;

   logic [31:0]               mag;
   logic                      still;

   // Squared flow magnitude against the still threshold (equal counts as moving)
   assign mag   = {1'b0, s1_word.sq_x} + {1'b0, s1_word.sq_y};
   assign still = (mag < threshold);

   // Next state for the current frame
   always_comb begin
      min_in     = min_ff;
      sel_idx_in = sel_idx_ff;
      ref_col_in = ref_col_ff;
      sel_col_in = sel_col_ff;
      if (cnt_ff == '0) begin
         // first frame of a run seeds everything
         min_in     = s1_word.gray;
         sel_idx_in = '0;
         ref_col_in = s1_word.colour;
         sel_col_in = s1_word.colour;
      end else if (still) begin
         if (s1_word.gray < min_ff) begin
            min_in     = s1_word.gray;
            sel_idx_in = cnt_ff;
            sel_col_in = s1_word.colour;
         end
      end else begin
         // motion: fall back to frame 0
         sel_idx_in = '0;
         sel_col_in = ref_col_ff;
      end

      if (s1_word.last) begin
         cnt_in = '0;
      end else if (cnt_ff == CntLast) begin
         cnt_in = cnt_ff;
      end else begin
         cnt_in = cnt_ff + 1'b1;
      end
   end

   // Frame counter
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (adv && s1_vld) begin
         cnt_ff <= cnt_in;
      end
   end

   // Run state; only read after the first frame of a run has written it
   always_ff @(posedge clock) begin
      if (adv && s1_vld) begin
         min_ff     <= min_in;
         sel_idx_ff <= sel_idx_in;
         ref_col_ff <= ref_col_in;
         sel_col_ff <= sel_col_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= s1_vld && s1_word.last;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && s1_vld && s1_word.last) begin
         out_col_ff <= sel_col_in;
         out_idx_ff <= sel_idx_in;
      end
   end

   // Result index is the low bits of the frame index
   assign idx_ext          = {{mgtms_pkg::IndexW{1'b0}}, out_idx_ff};
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_blue     = out_col_ff.blue;
   assign rsp_out_green    = out_col_ff.green;
   assign rsp_out_red      = out_col_ff.red;
   assign rsp_chosen_frame = idx_ext[mgtms_pkg::IndexW-1:0];

endmodule

>>> rtl/motion_gated_temporal_min_select.sv
// Top level of the motion gated temporal minimum select block.
// Depends on mgtms_pkg, mgtms_prep and mgtms_select.
//
// Usage:
//   req_*  : one word per frame of a pixel position, in frame order: BGR color,
//            signed Q8.8 flow, and req_last_frame on the final frame of the run.
//   rsp_*  : one word per run, sent after the word marked last: the color and
//            index of the selected frame.
//   csr_*  : write of the still threshold (squared flow, Q16.16). csr_ready is
//            always high; write only while no words are in flight.
// Pipeline: the last word of a run passes the input register, the square/gray
//   stage and the select stage before its result appears in rsp_valid.
// Throughput: one word per cycle; the pipeline is three registers deep and a
//   new word enters every cycle while the result register can move.
// Stall: when rsp_valid is high and rsp_ready low the whole pipeline holds and
//   req_ready drops; it rises again in the cycle the result is taken.
// Reset: synchronous, active high. Clears the pipeline, starts a new run at
//   frame 0 and restores the threshold to 0.01 (655).
module motion_gated_temporal_min_select #(
   parameter int unsigned MAX_FRAMES = mgtms_pkg::MaxFramesDefault
) (
   input  logic                     clock,
   input  logic                     reset,
   // input channel
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [7:0]               req_blue,
   input  logic [7:0]               req_green,
   input  logic [7:0]               req_red,
   input  logic signed [15:0]       req_flow_x,
   input  logic signed [15:0]       req_flow_y,
   input  logic                     req_last_frame,
   // result channel
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [7:0]               rsp_out_blue,
   output logic [7:0]               rsp_out_green,
   output logic [7:0]               rsp_out_red,
   output logic [mgtms_pkg::IndexW-1:0] rsp_chosen_frame,
   // configuration
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [31:0]              csr_still_threshold_sq
);

   logic                     adv;
   logic                     s1_vld;
   mgtms_pkg::s1_word_type   s1_word;
   logic [31:0]              thr_ff;

   // Pipeline moves whenever the result register is empty or being taken
   assign adv       = !rsp_valid || rsp_ready;
   assign req_ready = adv;
   assign csr_ready = 1'b1;

   // Still threshold register
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= mgtms_pkg::ThresholdReset;
      end else if (csr_valid) begin
         thr_ff <= csr_still_threshold_sq;
      end
   end

   mgtms_prep u_prep (
      .clock          (clock),
      .reset          (reset),
      .adv            (adv),
      .req_valid      (req_valid),
      .req_blue       (req_blue),
      .req_green      (req_green),
      .req_red        (req_red),
      .req_flow_x     (req_flow_x),
      .req_flow_y     (req_flow_y),
      .req_last_frame (req_last_frame),
      .s1_vld         (s1_vld),
      .s1_word        (s1_word)
   );

   mgtms_select #(
      .MAX_FRAMES (MAX_FRAMES)
   ) u_select (
      .clock            (clock),
      .reset            (reset),
      .adv              (adv),
      .s1_vld           (s1_vld),
      .s1_word          (s1_word),
      .threshold        (thr_ff),
      .rsp_valid        (rsp_valid),
      .rsp_out_blue     (rsp_out_blue),
      .rsp_out_green    (rsp_out_green),
      .rsp_out_red      (rsp_out_red),
      .rsp_chosen_frame (rsp_chosen_frame)
   );

endmodule

>>> rtl/mgtms_checker.sv
// Port-level assertions for motion_gated_temporal_min_select, bound to the top level.
// Depends on mgtms_pkg and on the top level's ports.
module mgtms_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_ready,
   input logic                     req_last_frame,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic [7:0]               rsp_out_blue,
   input logic [7:0]               rsp_out_green,
   input logic [7:0]               rsp_out_red,
   input logic [mgtms_pkg::IndexW-1:0] rsp_chosen_frame
);

   // A stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp_valid dropped while stalled");

   // A stalled result word keeps its value
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_out_blue) && $stable(rsp_out_green)
         && $stable(rsp_out_red) && $stable(rsp_chosen_frame))
      else $error("rsp word changed while stalled");

   // Input side only backs off while the result register is stalled
   a_ready_only_on_stall: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("req_ready low without a stalled result");

   // A last word reaches the result register when the pipeline is not stalled meanwhile
   a_last_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_last_frame) ##1 rsp_ready ##1 rsp_ready
         |=> rsp_valid)
      else $error("result for a last word did not appear");

endmodule

bind motion_gated_temporal_min_select mgtms_checker u_mgtms_checker (.*);
